// File: design/gwc_pkg.sv
// ----------------------------------------------------------------------------
// gwc_pkg
// Shared constants and types for the Galois word check unit.
// ----------------------------------------------------------------------------
package gwc_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int SYMBOL_W        = 8;

   typedef logic [SYMBOL_W-1:0] symbol_type;

   typedef struct packed {
      logic is_galois;
      logic rejected;
      logic overflow;
      logic word_end;
   } rsp_type;

endpackage

// File: design/gwc_if.sv
// ----------------------------------------------------------------------------
// gwc_if
// Valid/ready channels for the symbol stream and the per-beat verdict.
// ----------------------------------------------------------------------------
interface gwc_req_if;
   logic                valid;
   logic                ready;
   gwc_pkg::symbol_type symbol;
   logic                last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface gwc_rsp_if;
   logic valid;
   logic ready;
   logic is_galois;
   logic rejected;
   logic overflow;
   logic word_end;

   modport source (output valid, output is_galois, output rejected, output overflow,
                   output word_end, input ready);
   modport sink   (input valid, input is_galois, input rejected, input overflow,
                   input word_end, output ready);
endinterface

// File: design/gwc_symbol_store.sv
// ----------------------------------------------------------------------------
// gwc_symbol_store
// Symbol buffer: one write port, two registered read ports with write bypass.
// ----------------------------------------------------------------------------
module gwc_symbol_store #(
   parameter int MAX_LEN = gwc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_LEN)-1:0]   wr_addr,
   input  gwc_pkg::symbol_type          wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_LEN)-1:0]   rd_addr_even,
   input  logic [$clog2(MAX_LEN)-1:0]   rd_addr_odd,
   output gwc_pkg::symbol_type          rd_data_even,
   output gwc_pkg::symbol_type          rd_data_odd
);

   gwc_pkg::symbol_type symbol_mem_ff [MAX_LEN];
   gwc_pkg::symbol_type even_data_ff;
   gwc_pkg::symbol_type odd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         symbol_mem_ff[wr_addr] <= wr_data;
      end
      // the byte being written can be the one needed by the next beat
      if (rd_en) begin
         even_data_ff <= (wr_en && rd_addr_even == wr_addr) ? wr_data
                                                             : symbol_mem_ff[rd_addr_even];
         odd_data_ff  <= (wr_en && rd_addr_odd == wr_addr) ? wr_data
                                                            : symbol_mem_ff[rd_addr_odd];
      end
   end

   assign rd_data_even = even_data_ff;
   assign rd_data_odd  = odd_data_ff;

endmodule

// File: design/gwc_scan_core.sv
// ----------------------------------------------------------------------------
// gwc_scan_core
// Period tracking for one beat: compares, period update, verdict and the
// buffer addresses that the following beat will compare against.
// ----------------------------------------------------------------------------
module gwc_scan_core #(
   parameter int MAX_LEN = gwc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  gwc_pkg::symbol_type symbol,
   input  logic                last,
   output gwc_pkg::rsp_type    result
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int PW = $clog2(MAX_LEN + 2);
   localparam logic [PW-1:0] FULL_POS  = PW'(MAX_LEN);
   localparam logic [PW-1:0] ODD_INIT  = PW'(1);
   localparam logic [PW-1:0] EVEN_INIT = PW'(2);

   logic [PW-1:0] position_ff, position_in;
   logic [PW-1:0] odd_period_ff, odd_period_in;
   logic [PW-1:0] even_period_ff, even_period_in;
   logic          failed_ff, failed_in;
   logic          overflow_ff, overflow_in;

   logic                full;
   logic [AW-1:0]       j_addr;
   logic [PW-1:0]       j;
   logic                do_cmp;
   logic                even_hit, odd_hit;
   gwc_pkg::symbol_type b_even, b_odd;
   logic [PW-1:0]       pos_new, odd_new, even_new, pos_next, odd_next, even_next;
   logic                fail_new, ovf_new;
   logic [AW-1:0]       rd_addr_even, rd_addr_odd;

   gwc_symbol_store #(.MAX_LEN(MAX_LEN)) u_store (
      .clock        (clock),
      .wr_en        (step && !full),
      .wr_addr      (j_addr),
      .wr_data      (symbol),
      .rd_en        (step),
      .rd_addr_even (rd_addr_even),
      .rd_addr_odd  (rd_addr_odd),
      .rd_data_even (b_even),
      .rd_data_odd  (b_odd)
   );

   assign full   = (position_ff == FULL_POS);
   assign j_addr = position_ff[AW-1:0];
   assign j      = position_ff;
   assign do_cmp = !full && (position_ff != '0) && !failed_ff;

   assign even_hit = (even_period_ff <= j);
   assign odd_hit  = (odd_period_ff <= j);

   always_comb begin
      odd_new  = odd_period_ff;
      even_new = even_period_ff;
      fail_new = failed_ff;
      ovf_new  = overflow_ff;
      pos_new  = position_ff;
      if (full) begin
         ovf_new = 1'b1;
      end else begin
         pos_new = j + PW'(1);
         if (do_cmp) begin
            if (!j[0]) begin
               // odd 1-based position: ascending
               if (even_hit) begin
                  if (symbol < b_even) begin
                     fail_new = 1'b1;
                  end else if (symbol > b_even) begin
                     even_new = j + PW'(2);
                  end
               end
               if (odd_hit) begin
                  if (symbol < b_odd) begin
                     odd_new = j + PW'(1);
                  end else if (symbol > b_odd) begin
                     fail_new = 1'b1;
                  end
               end
            end else begin
               // even 1-based position: descending
               if (even_hit) begin
                  if (symbol > b_even) begin
                     fail_new = 1'b1;
                  end else if (symbol < b_even) begin
                     even_new = j + PW'(1);
                  end
               end
               if (odd_hit) begin
                  if (symbol > b_odd) begin
                     odd_new = j + PW'(2);
                  end else if (symbol < b_odd) begin
                     fail_new = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign result.is_galois = !fail_new && !ovf_new &&
                             ((odd_new == pos_new) ||
                              ((even_new == pos_new) &&
                               ({1'b0, even_new} != {odd_new, 1'b0})));
   assign result.rejected  = fail_new;
   assign result.overflow  = ovf_new;
   assign result.word_end  = last;

   assign pos_next  = last ? '0 : pos_new;
   assign odd_next  = last ? ODD_INIT : odd_new;
   assign even_next = last ? EVEN_INIT : even_new;

   // addresses for the next beat; out-of-range values are never compared
   assign rd_addr_even = AW'(pos_next - even_next);
   assign rd_addr_odd  = AW'(pos_next - odd_next);

   always_comb begin
      position_in    = position_ff;
      odd_period_in  = odd_period_ff;
      even_period_in = even_period_ff;
      failed_in      = failed_ff;
      overflow_in    = overflow_ff;
      if (step) begin
         position_in    = pos_next;
         odd_period_in  = odd_next;
         even_period_in = even_next;
         failed_in      = fail_new && !last;
         overflow_in    = ovf_new && !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         odd_period_ff  <= ODD_INIT;
         even_period_ff <= EVEN_INIT;
         failed_ff      <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         position_ff    <= position_in;
         odd_period_ff  <= odd_period_in;
         even_period_ff <= even_period_in;
         failed_ff      <= failed_in;
         overflow_ff    <= overflow_in;
      end
   end

endmodule

// File: design/galois_word_check_unit.sv
// Path: an accepted req beat enters the input reg; its verdict then enters the result reg.
// Throughput: one beat per cycle unless the rsp side stalls; the buffer reads for a beat
// are issued while the previous beat is scanned, so back-to-back beats never wait on the period loop.
// Reset: synchronous, active high; clears word state and both valid flags.
// The symbol buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// galois_word_check_unit
// Streaming Galois word recognizer under the alternating order.
// ----------------------------------------------------------------------------
module galois_word_check_unit #(
   parameter int MAX_LEN = gwc_pkg::MAX_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   gwc_req_if.sink    req_chan,
   gwc_rsp_if.source  rsp_chan
);

   logic                in_valid_ff, in_valid_in;
   gwc_pkg::symbol_type in_symbol_ff, in_symbol_in;
   logic                in_last_ff, in_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gwc_pkg::rsp_type    rsp_ff, rsp_in;
   gwc_pkg::rsp_type    result;
   logic                advance;
   logic                take;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   gwc_scan_core #(.MAX_LEN(MAX_LEN)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .symbol (in_symbol_ff),
      .last   (in_last_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_symbol_in = in_symbol_ff;
      in_last_in   = in_last_ff;
      if (take) begin
         in_valid_in  = 1'b1;
         in_symbol_in = req_chan.symbol;
         in_last_in   = req_chan.last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_symbol_ff <= in_symbol_in;
      in_last_ff   <= in_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.is_galois = rsp_ff.is_galois;
   assign rsp_chan.rejected  = rsp_ff.rejected;
   assign rsp_chan.overflow  = rsp_ff.overflow;
   assign rsp_chan.word_end  = rsp_ff.word_end;

endmodule

// File: test/galois_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// galois_verdict_checker
// Watches the symbol and verdict channels of the Galois word check unit. Each
// accepted symbol beat is run through a local recognizer for the alternating
// order. The recognizer keeps its own buffer, periods and flags. Each verdict
// beat is compared field by field with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module galois_verdict_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  gwc_pkg::symbol_type req_symbol,
   input  logic                req_last,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_is_galois,
   input  logic                rsp_rejected,
   input  logic                rsp_overflow,
   input  logic                rsp_word_end,
   output int                  verdicts_due,
   output int                  mismatch_count
);

   localparam int MAX_LEN = gwc_pkg::MAX_LEN_DEFAULT;

   gwc_pkg::symbol_type word_buf [MAX_LEN];
   logic [6:0]          word_len;
   logic [6:0]          odd_per;
   logic [6:0]          even_per;
   logic                word_failed;
   logic                word_overflow;
   gwc_pkg::rsp_type    verdict_q [$];

   function automatic void clear_word();
      word_len      = 7'd0;
      odd_per       = 7'd1;
      even_per      = 7'd2;
      word_failed   = 1'b0;
      word_overflow = 1'b0;
   endfunction

   function automatic gwc_pkg::symbol_type buf_at(input logic [6:0] idx);
      return word_buf[idx[5:0]];
   endfunction

   // Compare byte c at 0-based index j against the bytes one period back.
   function automatic void compare_periods(input logic [6:0] j,
                                           input gwc_pkg::symbol_type c);
      gwc_pkg::symbol_type b;
      if (j[0] == 1'b0) begin
         // odd 1-based position: ascending
         if (even_per <= j) begin
            b = buf_at(j - even_per);
            if (c < b) begin
               word_failed = 1'b1;
               return;
            end
            if (c > b) even_per = j + 7'd2;
         end
         if (odd_per <= j) begin
            b = buf_at(j - odd_per);
            if (c < b) odd_per = j + 7'd1;
            else if (c > b) begin
               word_failed = 1'b1;
               return;
            end
         end
      end else begin
         // even 1-based position: descending
         if (even_per <= j) begin
            b = buf_at(j - even_per);
            if (c > b) begin
               word_failed = 1'b1;
               return;
            end
            if (c < b) even_per = j + 7'd1;
         end
         if (odd_per <= j) begin
            b = buf_at(j - odd_per);
            if (c > b) odd_per = j + 7'd2;
            else if (c < b) begin
               word_failed = 1'b1;
               return;
            end
         end
      end
   endfunction

   function automatic gwc_pkg::rsp_type next_verdict(input gwc_pkg::symbol_type c,
                                                     input logic lst);
      gwc_pkg::rsp_type v;
      if (word_len >= MAX_LEN) begin
         word_overflow = 1'b1;
      end else begin
         word_buf[word_len[5:0]] = c;
         if (word_len != 7'd0 && !word_failed) compare_periods(word_len, c);
         word_len = word_len + 7'd1;
      end
      // 2*odd_per can exceed 7 bits, so compare at 8 bits
      v.is_galois = !word_failed && !word_overflow &&
                    (odd_per == word_len ||
                     (even_per == word_len && {1'b0, even_per} != {odd_per, 1'b0}));
      v.rejected  = word_failed;
      v.overflow  = word_overflow;
      v.word_end  = lst;
      if (lst) clear_word();
      return v;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      gwc_pkg::rsp_type got;
      gwc_pkg::rsp_type want;
      gwc_pkg::rsp_type pred;
      if (reset) begin
         clear_word();
         verdict_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            pred = next_verdict(req_symbol, req_last);
            verdict_q.insert(verdict_q.size(), pred);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_is_galois, rsp_rejected, rsp_overflow, rsp_word_end};
            if (verdict_q.size() == 0) begin
               $error("verdict beat with no verdict pending");
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               check_field("is_galois", want.is_galois, got.is_galois);
               check_field("rejected", want.rejected, got.rejected);
               check_field("overflow", want.overflow, got.overflow);
               check_field("word_end", want.word_end, got.word_end);
            end
         end
      end
      verdicts_due = verdict_q.size();
   end

endmodule

// File: test/galois_word_check_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// galois_word_check_unit_tb
// Drives words into the Galois word check unit, first a few hand-picked ones,
// then random words. Most random words use small alphabets or periodic shapes
// so that prefixes survive long. Some are long enough to overflow the buffer.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module galois_word_check_unit_tb;

   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;
   int   verdicts_due;
   int   mismatch_count;
   int   cycle_count = 0;
   int   items_sent;
   int   burst_left;

   gwc_pkg::symbol_type word_q [$];

   gwc_req_if req_bus ();
   gwc_rsp_if rsp_bus ();

   galois_word_check_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   galois_verdict_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_symbol     (req_bus.symbol),
      .req_last       (req_bus.last),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_is_galois  (rsp_bus.is_galois),
      .rsp_rejected   (rsp_bus.rejected),
      .rsp_overflow   (rsp_bus.overflow),
      .rsp_word_end   (rsp_bus.word_end),
      .verdicts_due   (verdicts_due),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic void append_symbol(input gwc_pkg::symbol_type s);
      word_q.insert(word_q.size(), s);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input gwc_pkg::symbol_type sym, input logic lst);
      int gap_len;
      if (burst_left == 0) begin
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap_len > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      req_bus.last   <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_word();
      for (int i = 0; i < word_q.size(); i++) send_beat(word_q[i], i == word_q.size() - 1);
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(1, 8);
      if (roll < 85) return $urandom_range(9, 30);
      if (roll < 95) return $urandom_range(31, 62);
      return $urandom_range(63, 70);
   endfunction

   task automatic build_word(input int len);
      gwc_pkg::symbol_type alpha [3];
      int                  kind;
      int                  span;
      int                  plen;
      kind = $urandom_range(0, 9);
      foreach (alpha[k]) alpha[k] = gwc_pkg::symbol_type'($urandom_range(0, 255));
      // neighboring values some of the time, so ties and near misses show up
      if ($urandom_range(0, 2) == 0) begin
         alpha[1] = alpha[0] + 8'd1;
         alpha[2] = alpha[0] - 8'd1;
      end
      span = (kind <= 3) ? 2 : 3;
      word_q.delete();
      if (kind <= 6) begin
         for (int i = 0; i < len; i++) append_symbol(alpha[$urandom_range(0, span - 1)]);
      end else if (kind <= 8) begin
         // repeated block, last byte sometimes bent
         plen = $urandom_range(1, 4);
         for (int i = 0; i < plen; i++) append_symbol(alpha[$urandom_range(0, 2)]);
         for (int i = plen; i < len; i++) append_symbol(word_q[i - plen]);
         while (word_q.size() > len) void'(word_q.pop_back());
         if ($urandom_range(0, 1) == 0) word_q[len - 1] = alpha[$urandom_range(0, 2)];
      end else begin
         for (int i = 0; i < len; i++)
            append_symbol(gwc_pkg::symbol_type'($urandom_range(0, 255)));
      end
   endtask

   // receiver: stretches of different stall patterns, two long hold-offs
   initial begin : receiver
      int mode;
      int span;
      int stretch;
      rsp_bus.ready = 1'b0;
      stretch       = 0;
      @(negedge reset);
      forever begin
         stretch++;
         if (stretch == 3 || stretch == 8) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (48) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      req_bus.valid  = 1'b0;
      req_bus.symbol = '0;
      req_bus.last   = 1'b0;
      reset          = 1'b1;
      items_sent     = 0;
      burst_left     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-byte words at both extremes
      word_q = '{8'h00};
      send_word();
      word_q = '{8'hFF};
      send_word();
      // rise at the even position: Galois through the even period
      word_q = '{8'h00, 8'hFF};
      send_word();
      // fall at the even position: rejected, later bytes still counted
      word_q = '{8'hFF, 8'h00, 8'h7F, 8'h80};
      send_word();
      // all equal bytes
      word_q = '{8'h05, 8'h05, 8'h05};
      send_word();
      // alternating bit patterns, period moves forward
      word_q = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h54};
      send_word();
      word_q = '{8'h10, 8'h20, 8'h18, 8'h20, 8'h10, 8'h30};
      send_word();

      // open with words near and past the buffer size
      repeat (2) begin
         build_word($urandom_range(63, 70));
         send_word();
      end
      while (items_sent < RANDOM_ITEMS) begin
         build_word(pick_length());
         send_word();
      end
      req_bus.valid <= 1'b0;

      while (verdicts_due != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/gwc_pkg.sv
design/gwc_if.sv
design/gwc_symbol_store.sv
design/gwc_scan_core.sv
design/galois_word_check_unit.sv
test/galois_verdict_checker.sv
test/galois_word_check_unit_tb.sv
